// File: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond, clk_sig, rst_sig) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, ante, cons, clk_sig, rst_sig) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/ledps_pkg.sv
package ledps_pkg;

  // Item kinds
  localparam logic [1:0] MODE_TIME  = 2'd0;
  localparam logic [1:0] MODE_PAT   = 2'd1;
  localparam logic [1:0] MODE_LEVEL = 2'd2;

  // Pattern codes
  localparam logic [2:0] PAT_ON     = 3'd0;
  localparam logic [2:0] PAT_OFF    = 3'd1;
  localparam logic [2:0] PAT_BLINK  = 3'd2;
  localparam logic [2:0] PAT_SOS    = 3'd3;
  localparam logic [2:0] PAT_BEACON = 3'd4;

  localparam logic [4:0]  SOS_STEPS     = 5'd18;
  localparam logic [3:0]  BEACON_LIMIT  = 4'd12;
  localparam logic [19:0] BEACON_US     = 20'd80000;
  localparam logic [25:0] MIN_BLINK_US  = 26'd50000;
  localparam logic [25:0] US_PER_MS     = 26'd1000;
  localparam logic [15:0] BLINK_MS_RST  = 16'd500;
  localparam logic [25:0] BLINK_US_RST  = 26'd500000;

  // Register map (byte address bit 2 selects the register slot)
  localparam logic REG_BLINK_INTERVAL = 1'b0;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] now_us;
    logic [2:0]  new_pattern;
    logic        new_level;
  } in_t;

  typedef struct packed {
    logic       led_level;
    logic [2:0] active_pattern;
  } out_t;

  typedef struct packed {
    logic [2:0]  pattern;
    logic        level;
    logic [63:0] last_step_time;
    logic [4:0]  sos_position;
    logic [3:0]  beacon_toggles;
  } state_t;

  // SOS hold time of each step, in microseconds
  function automatic logic [19:0] sos_hold_us(input logic [4:0] pos);
    logic [19:0] h;
    unique case (pos)
      5'd5, 5'd11:          h = 20'd300000;
      5'd6, 5'd8, 5'd10:    h = 20'd450000;
      5'd17:                h = 20'd1000000;
      default:              h = 20'd150000;
    endcase
    return h;
  endfunction

  // SOS level: on at even steps, off at odd steps
  function automatic logic sos_level(input logic [4:0] pos);
    return ~pos[0];
  endfunction

endpackage

// File: src/ledps_step.sv
// Next-state logic for one item: one 64-bit subtract and compare plus small updates.
module ledps_step (
  input  ledps_pkg::state_t st,
  input  ledps_pkg::in_t    item,
  input  logic [25:0]       blink_iv_us,
  output ledps_pkg::state_t st_next
);

  logic [63:0] elapsed;
  logic [4:0]  sos_pos;
  logic [4:0]  sos_pos_inc;
  logic [3:0]  toggles_inc;

  // Elapsed time wraps modulo 2^64
  assign elapsed     = item.now_us - st.last_step_time;
  assign sos_pos     = (st.sos_position < ledps_pkg::SOS_STEPS) ? st.sos_position : 5'd0;
  assign sos_pos_inc = (sos_pos + 5'd1 >= ledps_pkg::SOS_STEPS) ? 5'd0 : sos_pos + 5'd1;
  assign toggles_inc = st.beacon_toggles + 4'd1;

  always_comb begin
    st_next = st;
    unique case (item.mode)
      ledps_pkg::MODE_TIME: begin
        unique case (st.pattern)
          ledps_pkg::PAT_ON:  st_next.level = 1'b1;
          ledps_pkg::PAT_OFF: st_next.level = 1'b0;
          ledps_pkg::PAT_BLINK: begin
            if (elapsed >= 64'(blink_iv_us)) begin
              st_next.last_step_time = item.now_us;
              st_next.level          = ~st.level;
            end
          end
          ledps_pkg::PAT_SOS: begin
            if (elapsed >= 64'(ledps_pkg::sos_hold_us(sos_pos))) begin
              st_next.last_step_time = item.now_us;
              st_next.sos_position   = sos_pos_inc;
              st_next.level          = ledps_pkg::sos_level(sos_pos_inc);
            end
          end
          ledps_pkg::PAT_BEACON: begin
            if (elapsed >= 64'(ledps_pkg::BEACON_US)) begin
              st_next.last_step_time = item.now_us;
              st_next.level          = ~st.level;
              // fall back to blink after the last toggle
              if (toggles_inc >= ledps_pkg::BEACON_LIMIT) begin
                st_next.beacon_toggles = 4'd0;
                st_next.pattern        = ledps_pkg::PAT_BLINK;
              end else begin
                st_next.beacon_toggles = toggles_inc;
              end
            end
          end
          default: ;
        endcase
      end
      ledps_pkg::MODE_PAT: begin
        if (item.new_pattern <= ledps_pkg::PAT_BEACON) st_next.pattern = item.new_pattern;
      end
      ledps_pkg::MODE_LEVEL: st_next.level = item.new_level;
      default: ;
    endcase
  end

endmodule

// File: src/led_pattern_sequencer_unit.sv
// LED pattern sequencer. Takes one item per clock cycle (time sample, pattern
// write or level write) while the result channel is not stalled, and returns
// one result beat per item, giving the LED level and the active pattern after
// that item. An input register feeds a result register; a stalled result holds
// the input register, and a new input beat enters only while it is empty or
// its item moves on. The state update is a 64-bit elapsed-time subtract and
// compare. The blink half period is written at APB byte address 0 in
// milliseconds; its microsecond threshold (floored to 50 ms) is worked out
// when the register is written. There is no memory and no start-up pass.
`include "assert_macros.svh"

module led_pattern_sequencer_unit (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  ledps_pkg::in_t     in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output ledps_pkg::out_t    out_data,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic              s1_valid;
  ledps_pkg::in_t    s1_item;
  ledps_pkg::state_t st;
  ledps_pkg::state_t st_next;
  logic [15:0]       blink_interval_ms;
  logic [25:0]       blink_iv_us;
  logic [25:0]       blink_iv_us_next;
  logic              move;
  logic              cfg_wr;

  // Item moves from the input register into the result register
  assign move     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || move;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == ledps_pkg::REG_BLINK_INTERVAL);
  assign prdata = (paddr[2] == ledps_pkg::REG_BLINK_INTERVAL) ? 32'(blink_interval_ms) : 32'd0;

  always_comb begin
    blink_iv_us_next = 26'(pwdata[15:0]) * ledps_pkg::US_PER_MS;
    if (blink_iv_us_next < ledps_pkg::MIN_BLINK_US) blink_iv_us_next = ledps_pkg::MIN_BLINK_US;
  end

  ledps_step u_step (
    .st          (st),
    .item        (s1_item),
    .blink_iv_us (blink_iv_us),
    .st_next     (st_next)
  );

  // Control and sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid          <= 1'b0;
      out_valid         <= 1'b0;
      blink_interval_ms <= ledps_pkg::BLINK_MS_RST;
      blink_iv_us       <= ledps_pkg::BLINK_US_RST;
      st.pattern        <= ledps_pkg::PAT_BLINK;
      st.level          <= 1'b1;
      st.last_step_time <= 64'd0;
      st.sos_position   <= 5'd0;
      st.beacon_toggles <= 4'd0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (move) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        blink_interval_ms <= pwdata[15:0];
        blink_iv_us       <= blink_iv_us_next;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_item <= in_data;
    if (move) begin
      out_data.led_level      <= st_next.level;
      out_data.active_pattern <= st_next.pattern;
    end
  end

  `ASSERT_ALWAYS(a_pattern_legal, st.pattern <= ledps_pkg::PAT_BEACON, clk, rst)
  `ASSERT_ALWAYS(a_sos_pos_range, st.sos_position < ledps_pkg::SOS_STEPS, clk, rst)
  `ASSERT_ALWAYS(a_beacon_range, st.beacon_toggles < ledps_pkg::BEACON_LIMIT, clk, rst)
  `ASSERT_NEXT(a_move_gives_result, move, out_valid && out_data.active_pattern == st.pattern, clk, rst)

endmodule
